// ----- design/erot_pkg.sv -----
// ----------------------------------------------------------------------------
// erot_pkg - shared types and constants
// Angle encodings, CORDIC arctangent table and fixed-point helpers.
// ----------------------------------------------------------------------------
package erot_pkg;

  localparam int ATAN_STEPS  = 24;
  localparam int DEG_TURN    = 23040;
  localparam int DEG_HALF    = 11520;
  localparam int DEG_QUARTER = 5760;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [17:0] Q14_ONE = 18'sd16384;

  typedef logic signed [15:0] q14_t;
  typedef logic signed [33:0] cw_t;

  typedef struct packed {
    logic signed [15:0] pitch_deg;
    logic signed [15:0] yaw_deg;
    logic signed [15:0] roll_deg;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } in_item_t;

  typedef struct packed {
    q14_t m00; q14_t m01; q14_t m02;
    q14_t m10; q14_t m11; q14_t m12;
    q14_t m20; q14_t m21; q14_t m22;
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
  } out_item_t;

  // One lane's view of the CORDIC state.
  typedef struct packed {
    cw_t                x;
    cw_t                y;
    logic signed [31:0] z;
    logic               neg_cos;
  } lane_t;

  function automatic logic signed [31:0] atan_q22(input int i);
    case (i)
      0: return 32'sd188743680;  1: return 32'sd111421900;
      2: return 32'sd58872272;   3: return 32'sd29884485;
      4: return 32'sd15000234;   5: return 32'sd7507429;
      6: return 32'sd3754631;    7: return 32'sd1877430;
      8: return 32'sd938729;     9: return 32'sd469366;
      10: return 32'sd234683;    11: return 32'sd117342;
      12: return 32'sd58671;     13: return 32'sd29335;
      14: return 32'sd14668;     15: return 32'sd7334;
      16: return 32'sd3667;      17: return 32'sd1833;
      18: return 32'sd917;       19: return 32'sd458;
      20: return 32'sd229;       21: return 32'sd115;
      22: return 32'sd57;        23: return 32'sd29;
      default: return 32'sd0;
    endcase
  endfunction

  function automatic q14_t clamp14(input logic signed [47:0] v);
    if (v > 48'sd16384) return 16'sd16384;
    if (v < -48'sd16384) return -16'sd16384;
    return v[15:0];
  endfunction

  // Q1.14 product with rounding, clamped.
  function automatic q14_t mul14(input q14_t a, input q14_t b);
    logic signed [31:0] p;
    p = a * b + 32'sd8192;
    return clamp14(48'(p >>> 14));
  endfunction

endpackage

// ----- design/erot_if.sv -----
// ----------------------------------------------------------------------------
// erot_in_if / erot_out_if - valid/ready channels
// Request channels carrying one input item or one result item.
// ----------------------------------------------------------------------------
interface erot_in_if;
  logic                     valid;
  logic                     ready;
  erot_pkg::in_item_t       data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface erot_out_if;
  logic                     valid;
  logic                     ready;
  erot_pkg::out_item_t      data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/erot_lane.sv -----
// ----------------------------------------------------------------------------
// erot_lane - pipelined CORDIC sine/cosine lane
// Reduces a Q10.6 degree angle and runs one CORDIC step per stage.
// ----------------------------------------------------------------------------
module erot_lane #(
  parameter int NSTEP = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [15:0]  angle,
  output erot_pkg::q14_t      sin_o,
  output erot_pkg::q14_t      cos_o
);
  import erot_pkg::*;

  lane_t st_r [NSTEP+1];
  logic signed [17:0] r;
  logic signed [17:0] rr;
  logic               ng;

  // Stage 0: wrap to (-180,180] and fold into [-90,90].
  always_comb begin
    r  = 18'(angle);
    if (r < 0) r = r + 18'(DEG_TURN);
    if (r > 18'(DEG_HALF)) r = r - 18'(DEG_TURN);
    rr = r;
    ng = 1'b0;
    if (r > 18'(DEG_QUARTER)) begin
      rr = 18'(DEG_HALF) - r;
      ng = 1'b1;
    end else if (r < -18'sd5760) begin
      rr = -18'(DEG_HALF) - r;
      ng = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0].x       <= CORDIC_GAIN;
      st_r[0].y       <= '0;
      st_r[0].z       <= 32'(rr) <<< 16;
      st_r[0].neg_cos <= ng;
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        st_r[i+1].neg_cos <= st_r[i].neg_cos;
        if (!st_r[i].z[31]) begin
          st_r[i+1].x <= st_r[i].x - (st_r[i].y >>> i);
          st_r[i+1].y <= st_r[i].y + (st_r[i].x >>> i);
          st_r[i+1].z <= st_r[i].z - atan_q22(i);
        end else begin
          st_r[i+1].x <= st_r[i].x + (st_r[i].y >>> i);
          st_r[i+1].y <= st_r[i].y - (st_r[i].x >>> i);
          st_r[i+1].z <= st_r[i].z + atan_q22(i);
        end
      end
    end
  end

  logic signed [33:0] xs;
  logic signed [33:0] ys;
  q14_t               xc;
  assign xs = (st_r[NSTEP].x + 34'sd32768) >>> 16;
  assign ys = (st_r[NSTEP].y + 34'sd32768) >>> 16;
  assign xc = clamp14(48'(xs));
  assign sin_o = clamp14(48'(ys));
  assign cos_o = st_r[NSTEP].neg_cos ? -xc : xc;

endmodule

// ----- design/erot_merge.sv -----
// ----------------------------------------------------------------------------
// erot_merge - matrix build and vector rotation
// Combines the three lanes' sines and cosines into the matrix, then
// rotates the delayed vector; four register stages.
// ----------------------------------------------------------------------------
module erot_merge (
  input  logic                 clk,
  input  logic                 en,
  input  erot_pkg::q14_t       sp, cp, sy, cy, sr, cr,
  input  logic signed [31:0]   vx, vy, vz,
  output erot_pkg::q14_t       m_o [9],
  output logic signed [31:0]   rot_o [3]
);
  import erot_pkg::*;

  // Stage A: pair products.
  q14_t crcy_r, crsy_r, srcy_r, srsy_r, sp_r, m00_r, m10_r, m20_r, m21_r, m22_r;
  // Stage B: full matrix.
  q14_t m_r [9];
  logic signed [31:0] va_r [3];
  logic signed [31:0] vb_r [3];
  // Stage C: nine products.
  logic signed [47:0] p_r [9];
  // Stage D: saturated sums.
  logic signed [31:0] rot_r [3];
  q14_t mc_r [9];

  function automatic logic signed [31:0] sat32(input logic signed [47:0] s);
    logic signed [47:0] t;
    t = (s + 48'sd8192) >>> 14;
    if (t > 48'sd2147483647) return 32'h7fffffff;
    if (t < -48'sd2147483648) return 32'h80000000;
    return t[31:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      crcy_r <= mul14(cr, cy);
      crsy_r <= mul14(cr, sy);
      srcy_r <= mul14(sr, cy);
      srsy_r <= mul14(sr, sy);
      sp_r   <= sp;
      m00_r  <= mul14(cp, cy);
      m10_r  <= mul14(cp, sy);
      m20_r  <= clamp14(-48'(sp));
      m21_r  <= mul14(sr, cp);
      m22_r  <= mul14(cr, cp);
      va_r   <= '{vx, vy, vz};

      m_r[0] <= m00_r;
      m_r[1] <= clamp14(48'(mul14(sp_r, srcy_r)) - 48'(crsy_r));
      m_r[2] <= clamp14(48'(mul14(sp_r, crcy_r)) + 48'(srsy_r));
      m_r[3] <= m10_r;
      m_r[4] <= clamp14(48'(mul14(sp_r, srsy_r)) + 48'(crcy_r));
      m_r[5] <= clamp14(48'(mul14(sp_r, crsy_r)) - 48'(srcy_r));
      m_r[6] <= m20_r;
      m_r[7] <= m21_r;
      m_r[8] <= m22_r;
      vb_r   <= va_r;

      for (int k = 0; k < 9; k++) begin
        p_r[k] <= 48'(m_r[k]) * 48'(vb_r[k % 3]);
      end
      mc_r <= m_r;

      for (int k = 0; k < 3; k++) begin
        rot_r[k] <= sat32(p_r[3*k] + p_r[3*k+1] + p_r[3*k+2]);
      end
      m_o <= mc_r;
    end
  end

  assign rot_o = rot_r;

endmodule

// ----- design/euler_rotation_matrix_and_rotate_core.sv -----
// ----------------------------------------------------------------------------
// euler_rotation_matrix_and_rotate_core - Euler angle rotation block
// Yaw*pitch*roll matrix from three angles and a rotated 3-vector.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries pitch, yaw, roll (Q10.6 degrees) and a Q16.16 vector.
//   out_ch returns the nine Q1.14 matrix entries and the rotated vector.
//   Three CORDIC lanes, one per angle, run side by side; a merge stage
//   forms the matrix products and the rotation dot products.
//   Throughput: one request per cycle while out_ch is not stalled. Each
//   request passes from acceptance to out_ch valid through one angle
//   reduction stage, NSTEP CORDIC stages and the four merge stages, where
//   NSTEP is TRIG_ITERATIONS limited to 0..24.
//   The whole pipeline advances as one; when the receiver stalls with a
//   result held at the output, every stage holds, bubbles included, and
//   in_ch.ready drops until the result is taken.
//   Reset clears the valid bits of every stage; data registers are not
//   reset. The block keeps no state between items.
// ----------------------------------------------------------------------------
module euler_rotation_matrix_and_rotate_core #(
  parameter int TRIG_ITERATIONS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  erot_in_if.sink     in_ch,
  erot_out_if.source  out_ch
);
  import erot_pkg::*;

  localparam int NSTEP = (TRIG_ITERATIONS > ATAN_STEPS) ? ATAN_STEPS :
                         (TRIG_ITERATIONS < 1) ? 0 : TRIG_ITERATIONS;
  localparam int LAT = NSTEP + 5;

  logic       adv;
  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] vld_nxt;

  // Advance unless the output holds an untaken result.
  assign adv = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    vld_nxt = vld_r;
    if (adv) vld_nxt = {vld_r[LAT-2:0], in_ch.valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= vld_nxt;
  end

  q14_t sp, cp, sy, cy, sr, cr;

  erot_lane #(.NSTEP(NSTEP)) u_pitch (
    .clk(clk), .en(adv), .angle(in_ch.data.pitch_deg), .sin_o(sp), .cos_o(cp));
  erot_lane #(.NSTEP(NSTEP)) u_yaw (
    .clk(clk), .en(adv), .angle(in_ch.data.yaw_deg), .sin_o(sy), .cos_o(cy));
  erot_lane #(.NSTEP(NSTEP)) u_roll (
    .clk(clk), .en(adv), .angle(in_ch.data.roll_deg), .sin_o(sr), .cos_o(cr));

  // Delay the vector to line up with the lane outputs.
  logic signed [95:0] vd_r [NSTEP+1];
  always_ff @(posedge clk) begin
    if (adv) begin
      vd_r[0] <= {in_ch.data.vec_x, in_ch.data.vec_y, in_ch.data.vec_z};
      for (int k = 1; k <= NSTEP; k++) vd_r[k] <= vd_r[k-1];
    end
  end

  q14_t               m [9];
  logic signed [31:0] rot [3];

  erot_merge u_merge (
    .clk(clk), .en(adv), .sp(sp), .cp(cp), .sy(sy), .cy(cy), .sr(sr), .cr(cr),
    .vx(vd_r[NSTEP][95:64]), .vy(vd_r[NSTEP][63:32]), .vz(vd_r[NSTEP][31:0]),
    .m_o(m), .rot_o(rot));

  assign out_ch.valid = vld_r[LAT-1];
  assign out_ch.data  = '{m00: m[0], m01: m[1], m02: m[2],
                          m10: m[3], m11: m[4], m12: m[5],
                          m20: m[6], m21: m[7], m22: m[8],
                          rot_x: rot[0], rot_y: rot[1], rot_z: rot[2]};

  // A stalled result must stay put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed under stall");
  // Ready tracks the output stall exactly.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready == (!out_ch.valid || out_ch.ready))
    else $error("ready mismatch");
  // Matrix entry m00 stays in Q1.14 range.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.m00 <= 16'sd16384 && out_ch.data.m00 >= -16'sd16384))
    else $error("m00 out of range");

endmodule
